FILE: hw/rtl/stack_to_queue_transfer_top_defines.svh
// assertion helpers for the stack to queue transfer block
// both expect clk and rst_n in the scope where they are used
`ifndef STACK_TO_QUEUE_TRANSFER_TOP_DEFINES_SVH
`define STACK_TO_QUEUE_TRANSFER_TOP_DEFINES_SVH

// same-cycle implication
`define STQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/stq_pkg.sv
package stq_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int QUEUE_DEPTH = 64;
  localparam int DATA_WIDTH  = 32;

  localparam int SA_W     = $clog2(STACK_DEPTH);
  localparam int SL_W     = $clog2(STACK_DEPTH + 1);
  localparam int QA_W     = $clog2(QUEUE_DEPTH);
  localparam int QL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int MOVED_W  = QL_W;

  typedef enum logic [KIND_W-1:0] {
    K_ENQ  = 3'd0,
    K_PUSH = 3'd1,
    K_POP  = 3'd2,
    K_DEQ  = 3'd3,
    K_XFER = 3'd4,
    K_DUMP = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_XFER,
    S_DUMP
  } state_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_STACK,
    SRC_QUEUE
  } data_src_t;

  // operation requests from the sequencer to the stores
  typedef struct packed {
    logic                  push;
    logic                  pop;
    logic                  enq;
    logic                  deq;
    logic                  xfer;
    logic                  dump_rd;
    logic [QA_W-1:0]       dump_addr;
    logic [DATA_WIDTH-1:0] wdata;
  } stq_cmd_t;

  // store occupancy seen by the sequencer
  typedef struct packed {
    logic            stack_empty;
    logic            stack_full;
    logic            queue_empty;
    logic            queue_full;
    logic            xfer_ok;
    logic [QA_W-1:0] queue_head;
    logic [QL_W-1:0] queue_level;
  } stq_sts_t;

  function automatic logic [QA_W-1:0] q_next(input logic [QA_W-1:0] p);
    q_next = (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

FILE: hw/rtl/stq_stores.sv
module stq_stores (
  input  logic                             clk,
  input  logic                             rst_n,
  input  stq_pkg::stq_cmd_t                cmd,
  output stq_pkg::stq_sts_t                sts,
  output logic [stq_pkg::DATA_WIDTH-1:0]   stack_rdata,
  output logic [stq_pkg::DATA_WIDTH-1:0]   queue_rdata
);
  import stq_pkg::*;

  logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] queue_mem [QUEUE_DEPTH];

  logic [SL_W-1:0]       stack_level_r, stack_level_nxt;
  logic [QA_W-1:0]       queue_head_r, queue_head_nxt;
  logic [QA_W-1:0]       queue_tail_r, queue_tail_nxt;
  logic [QL_W-1:0]       queue_level_r, queue_level_nxt;
  logic                  xfer_pend_r;
  logic [QA_W-1:0]       xfer_addr_r;
  logic [DATA_WIDTH-1:0] stack_rdata_r;
  logic [DATA_WIDTH-1:0] queue_rdata_r;

  logic                  stack_empty, stack_full, queue_empty, queue_full;
  logic [SL_W-1:0]       stack_top_full;
  logic [SA_W-1:0]       stack_top, stack_widx;
  logic                  do_push, do_stack_rd, xfer_mv, do_enq, do_deq;
  logic                  q_we, q_re;
  logic [QA_W-1:0]       q_waddr, q_raddr;
  logic [DATA_WIDTH-1:0] q_wdata;

  assign stack_empty    = (stack_level_r == '0);
  assign stack_full     = (stack_level_r == SL_W'(STACK_DEPTH));
  assign queue_empty    = (queue_level_r == '0);
  assign queue_full     = (queue_level_r == QL_W'(QUEUE_DEPTH));
  assign stack_top_full = stack_level_r - SL_W'(1);
  assign stack_top      = stack_top_full[SA_W-1:0];
  assign stack_widx     = stack_level_r[SA_W-1:0];

  assign do_push     = cmd.push & ~stack_full;
  assign xfer_mv     = cmd.xfer & ~stack_empty & ~queue_full;
  assign do_stack_rd = (cmd.pop & ~stack_empty) | xfer_mv;
  assign do_enq      = cmd.enq & ~queue_full;
  assign do_deq      = cmd.deq & ~queue_empty;

  // a transfer reserves its queue slot when the stack is read, the word is written in the following cycle
  assign q_we    = do_enq | xfer_pend_r;
  assign q_waddr = xfer_pend_r ? xfer_addr_r : queue_tail_r;
  assign q_wdata = xfer_pend_r ? stack_rdata_r : cmd.wdata;
  assign q_re    = do_deq | cmd.dump_rd;
  assign q_raddr = cmd.dump_rd ? cmd.dump_addr : queue_head_r;

  always_comb begin
    stack_level_nxt = stack_level_r;
    queue_head_nxt  = queue_head_r;
    queue_tail_nxt  = queue_tail_r;
    queue_level_nxt = queue_level_r;
    if (do_push) begin
      stack_level_nxt = stack_level_r + SL_W'(1);
    end else if (do_stack_rd) begin
      stack_level_nxt = stack_top_full;
    end
    if (do_enq || xfer_mv) begin
      queue_tail_nxt  = q_next(queue_tail_r);
      queue_level_nxt = queue_level_r + QL_W'(1);
    end else if (do_deq) begin
      queue_head_nxt  = q_next(queue_head_r);
      queue_level_nxt = queue_level_r - QL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_level_r <= '0;
      queue_head_r  <= '0;
      queue_tail_r  <= '0;
      queue_level_r <= '0;
      xfer_pend_r   <= 1'b0;
    end else begin
      stack_level_r <= stack_level_nxt;
      queue_head_r  <= queue_head_nxt;
      queue_tail_r  <= queue_tail_nxt;
      queue_level_r <= queue_level_nxt;
      xfer_pend_r   <= xfer_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer_mv) begin
      xfer_addr_r <= queue_tail_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[stack_widx] <= cmd.wdata;
    end
    if (do_stack_rd) begin
      stack_rdata_r <= stack_mem[stack_top];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      queue_rdata_r <= queue_mem[q_raddr];
    end
  end

  assign stack_rdata     = stack_rdata_r;
  assign queue_rdata     = queue_rdata_r;
  assign sts.stack_empty = stack_empty;
  assign sts.stack_full  = stack_full;
  assign sts.queue_empty = queue_empty;
  assign sts.queue_full  = queue_full;
  assign sts.xfer_ok     = ~stack_empty & ~queue_full;
  assign sts.queue_head  = queue_head_r;
  assign sts.queue_level = queue_level_r;

endmodule

FILE: hw/rtl/stack_to_queue_transfer_top.sv
// stack to queue transfer: a 64-word LIFO stack and a 64-word circular FIFO queue
// input channel: in_kind selects enqueue, push, pop, dequeue, transfer or dump,
// in_value carries the word for push and enqueue; unused kinds are taken and dropped
// result channel: out_status, out_data_out, out_moved_count, out_last; out_last marks
// the final result of each input transaction
// push, pop, enqueue, dequeue: one result, out_valid rises after acceptance once the
// S_RESP state has loaded the result into the output register
// transfer: one word per cycle through the stack read port into the queue write
// port, then a single result that carries the count of moved words
// dump: n results, the first loaded in S_DUMP, then one per cycle while
// out_stall is low, paced by the queue read port
// the block takes one transaction at a time: in_stall is high from acceptance until
// the last result is loaded into the output register
// out_stall holds the output register and pauses a dump; no result is lost
// reset (synchronous, rst_n low) empties both stores and clears out_valid; the
// store contents are not cleared and need no clearing pass
`include "stack_to_queue_transfer_top_defines.svh"

module stack_to_queue_transfer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [stq_pkg::KIND_W-1:0]     in_kind,
  input  logic [stq_pkg::DATA_WIDTH-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [stq_pkg::STATUS_W-1:0]   out_status,
  output logic [stq_pkg::DATA_WIDTH-1:0] out_data_out,
  output logic [stq_pkg::MOVED_W-1:0]    out_moved_count,
  output logic                           out_last
);
  import stq_pkg::*;

  state_t                state_r, state_nxt;
  status_t               res_status_r, res_status_nxt;
  data_src_t             res_src_r, res_src_nxt;
  logic [MOVED_W-1:0]    moved_r, moved_nxt;
  logic [QA_W-1:0]       dump_p_r, dump_p_nxt;
  logic [QL_W-1:0]       dump_left_r, dump_left_nxt;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic [MOVED_W-1:0]    out_moved_r;
  logic                  out_last_r;

  logic                  in_fire, out_free, load_out;
  status_t               ld_status;
  logic [DATA_WIDTH-1:0] ld_data;
  logic [MOVED_W-1:0]    ld_moved;
  logic                  ld_last;

  stq_cmd_t              cmd;
  stq_sts_t              sts;
  logic [DATA_WIDTH-1:0] stack_rdata, queue_rdata;
  logic [4:0]            cmd_ops;

  stq_stores u_stores (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .stack_rdata (stack_rdata),
    .queue_rdata (queue_rdata)
  );

  assign in_stall = ~rst_n | (state_r != S_IDLE);
  assign in_fire  = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_src_nxt    = res_src_r;
    moved_nxt      = moved_r;
    dump_p_nxt     = dump_p_r;
    dump_left_nxt  = dump_left_r;
    cmd            = '0;
    cmd.wdata      = in_value;
    cmd.dump_addr  = dump_p_r;
    load_out       = 1'b0;
    ld_status      = res_status_r;
    ld_data        = '0;
    ld_moved       = moved_r;
    ld_last        = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          moved_nxt   = '0;
          res_src_nxt = SRC_ZERO;
          case (kind_t'(in_kind))
            K_ENQ: begin
              cmd.enq        = 1'b1;
              res_status_nxt = sts.queue_full ? ST_FULL : ST_OK;
              state_nxt      = S_RESP;
            end
            K_PUSH: begin
              cmd.push       = 1'b1;
              res_status_nxt = sts.stack_full ? ST_FULL : ST_OK;
              state_nxt      = S_RESP;
            end
            K_POP: begin
              cmd.pop        = 1'b1;
              res_status_nxt = sts.stack_empty ? ST_EMPTY : ST_OK;
              res_src_nxt    = sts.stack_empty ? SRC_ZERO : SRC_STACK;
              state_nxt      = S_RESP;
            end
            K_DEQ: begin
              cmd.deq        = 1'b1;
              res_status_nxt = sts.queue_empty ? ST_EMPTY : ST_OK;
              res_src_nxt    = sts.queue_empty ? SRC_ZERO : SRC_QUEUE;
              state_nxt      = S_RESP;
            end
            K_XFER: begin
              state_nxt = S_XFER;
            end
            K_DUMP: begin
              if (sts.queue_empty) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                cmd.dump_rd   = 1'b1;
                cmd.dump_addr = sts.queue_head;
                dump_p_nxt    = q_next(sts.queue_head);
                dump_left_nxt = sts.queue_level - QL_W'(1);
                state_nxt     = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RESP: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          case (res_src_r)
            SRC_STACK: ld_data = stack_rdata;
            SRC_QUEUE: ld_data = queue_rdata;
            default:   ld_data = '0;
          endcase
        end
      end

      S_XFER: begin
        // one word moves per cycle until the stack runs dry or the queue fills
        cmd.xfer = 1'b1;
        if (sts.xfer_ok) begin
          moved_nxt = moved_r + MOVED_W'(1);
        end else begin
          res_status_nxt = sts.stack_empty ? ST_OK : ST_FULL;
          state_nxt      = S_RESP;
        end
      end

      S_DUMP: begin
        if (out_free) begin
          load_out  = 1'b1;
          ld_status = ST_OK;
          ld_data   = queue_rdata;
          ld_moved  = '0;
          ld_last   = (dump_left_r == '0);
          if (dump_left_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            // next word is read as this one goes into the output register
            cmd.dump_rd   = 1'b1;
            dump_p_nxt    = q_next(dump_p_r);
            dump_left_nxt = dump_left_r - QL_W'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_src_r    <= res_src_nxt;
    moved_r      <= moved_nxt;
    dump_p_r     <= dump_p_nxt;
    dump_left_r  <= dump_left_nxt;
    if (load_out) begin
      out_status_r <= ld_status;
      out_data_r   <= ld_data;
      out_moved_r  <= ld_moved;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_out    = out_data_r;
  assign out_moved_count = out_moved_r;
  assign out_last        = out_last_r;

  assign cmd_ops = {cmd.push, cmd.pop, cmd.enq, cmd.deq, cmd.xfer};

  `STQ_ASSERT_IMPL(a_one_store_op, 1'b1, $onehot0(cmd_ops), "several store operations at once")
  `STQ_ASSERT_IMPL(a_queue_bound, 1'b1, sts.queue_level <= QL_W'(QUEUE_DEPTH), "queue overfilled")
  `STQ_ASSERT_NEXT(a_pop_resp, in_fire && in_kind == K_POP, state_r == S_RESP, "pop not answered")
  `STQ_ASSERT_NEXT(a_dump_end, state_r == S_DUMP && load_out && dump_left_r == '0, state_r == S_IDLE && out_valid_r && out_last_r, "dump did not end with last")

endmodule

FILE: tb/stq_result_checker.sv
module stq_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [stq_pkg::KIND_W-1:0]     in_kind,
  input  logic [stq_pkg::DATA_WIDTH-1:0] in_value,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [stq_pkg::STATUS_W-1:0]   out_status,
  input  logic [stq_pkg::DATA_WIDTH-1:0] out_data_out,
  input  logic [stq_pkg::MOVED_W-1:0]    out_moved_count,
  input  logic                           out_last,
  output int                             n_fail,
  output int                             n_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import stq_pkg::*;

  typedef struct packed {
    status_t               status;
    logic [DATA_WIDTH-1:0] data;
    logic [MOVED_W-1:0]    moved;
    logic                  last;
  } result_t;

  result_t expected_results[$];

  logic [DATA_WIDTH-1:0] stk_mem [STACK_DEPTH];
  logic [SL_W-1:0]       stk_lvl;
  logic [DATA_WIDTH-1:0] q_mem [QUEUE_DEPTH];
  logic [QA_W-1:0]       q_rd;
  logic [QA_W-1:0]       q_wr;
  logic [QL_W-1:0]       q_lvl;

  function automatic logic [QA_W-1:0] ring_inc(input logic [QA_W-1:0] p);
    return (p == QA_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  task automatic note_result(input status_t st, input logic [DATA_WIDTH-1:0] d,
                             input logic [MOVED_W-1:0] m, input logic l);
    result_t r;
    r.status = st;
    r.data   = d;
    r.moved  = m;
    r.last   = l;
    expected_results.push_back(r);
  endtask

  task automatic store_to_queue(input logic [DATA_WIDTH-1:0] w);
    q_mem[q_wr] = w;
    q_wr = ring_inc(q_wr);
    q_lvl = q_lvl + 1'b1;
  endtask

  // update the stack and queue image for one operation and queue its results
  task automatic apply_op(input logic [KIND_W-1:0] kind, input logic [DATA_WIDTH-1:0] value);
    logic [MOVED_W-1:0] moved;
    logic [QA_W-1:0]    rd;
    logic [QL_W-1:0]    i;
    case (kind)
      K_ENQ: begin
        if (q_lvl == QL_W'(QUEUE_DEPTH)) begin
          note_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          store_to_queue(value);
          note_result(ST_OK, '0, '0, 1'b1);
        end
      end
      K_PUSH: begin
        if (stk_lvl == SL_W'(STACK_DEPTH)) begin
          note_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          stk_mem[stk_lvl[SA_W-1:0]] = value;
          stk_lvl = stk_lvl + 1'b1;
          note_result(ST_OK, '0, '0, 1'b1);
        end
      end
      K_POP: begin
        if (stk_lvl == '0) begin
          note_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          stk_lvl = stk_lvl - 1'b1;
          note_result(ST_OK, stk_mem[stk_lvl[SA_W-1:0]], '0, 1'b1);
        end
      end
      K_DEQ: begin
        if (q_lvl == '0) begin
          note_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          note_result(ST_OK, q_mem[q_rd], '0, 1'b1);
          q_rd = ring_inc(q_rd);
          q_lvl = q_lvl - 1'b1;
        end
      end
      K_XFER: begin
        moved = '0;
        // words leave from the top of the stack until it empties or the queue fills
        while (stk_lvl != '0 && q_lvl != QL_W'(QUEUE_DEPTH)) begin
          stk_lvl = stk_lvl - 1'b1;
          store_to_queue(stk_mem[stk_lvl[SA_W-1:0]]);
          moved = moved + 1'b1;
        end
        note_result((stk_lvl != '0) ? ST_FULL : ST_OK, '0, moved, 1'b1);
      end
      K_DUMP: begin
        if (q_lvl == '0) begin
          note_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          rd = q_rd;
          for (i = '0; i < q_lvl; i = i + 1'b1) begin
            note_result(ST_OK, q_mem[rd], '0, i == q_lvl - 1'b1);
            rd = ring_inc(rd);
          end
        end
      end
      default: ; // spare kinds are swallowed without a result
    endcase
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      stk_lvl = '0;
      q_rd    = '0;
      q_wr    = '0;
      q_lvl   = '0;
      expected_results.delete();
      n_fail  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%t: unexpected result status=%0d data=%h moved=%0d last=%b",
                     $realtime, out_status, out_data_out, out_moved_count, out_last);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status || out_data_out !== want.data ||
              out_moved_count !== want.moved || out_last !== want.last) begin
            n_fail++;
            if (n_fail <= 10)
              $display({"%t: result mismatch exp status=%0d data=%h moved=%0d last=%b,",
                        " got status=%0d data=%h moved=%0d last=%b"},
                       $realtime, want.status, want.data, want.moved, want.last,
                       out_status, out_data_out, out_moved_count, out_last);
          end
        end
      end
      if (in_valid && !in_stall)
        apply_op(in_kind, in_value);
    end
    n_pending = expected_results.size();
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import stq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [KIND_W-1:0]     in_kind;
  logic [DATA_WIDTH-1:0] in_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   out_status;
  logic [DATA_WIDTH-1:0] out_data_out;
  logic [MOVED_W-1:0]    out_moved_count;
  logic                  out_last;
  int                    n_fail;
  int                    n_pending;
  bit                    src_gaps;
  bit                    sink_gaps;

  stack_to_queue_transfer_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_moved_count (out_moved_count),
    .out_last        (out_last)
  );

  stq_result_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_moved_count (out_moved_count),
    .out_last        (out_last),
    .n_fail          (n_fail),
    .n_pending       (n_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver holds off in random bursts
  always begin
    @(negedge clk);
    if (sink_gaps && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 18)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic issue_op(input logic [KIND_W-1:0] kind, input logic [DATA_WIDTH-1:0] value);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int r;
    logic [KIND_W-1:0] k;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_kind   = '0;
    in_value  = '0;
    out_stall = 1'b0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty stores, extremes of the data word, spare kinds
    issue_op(K_DUMP, '0);
    issue_op(K_POP, '0);
    issue_op(K_DEQ, '1);
    issue_op(K_XFER, '0);
    issue_op(K_PUSH, '0);
    issue_op(K_PUSH, '1);
    issue_op(K_ENQ, '0);
    issue_op(K_ENQ, '1);
    issue_op(KIND_SPARE6, '1);
    issue_op(KIND_SPARE7, 32'h5a5a_a5a5);
    issue_op(K_DUMP, '1);
    issue_op(K_XFER, '1);
    issue_op(K_DUMP, '0);
    issue_op(K_DEQ, '0);
    issue_op(K_DEQ, '0);
    issue_op(K_POP, '0);
    issue_op(K_PUSH, 32'h8000_0001);
    issue_op(K_POP, '0);
    issue_op(K_DEQ, '0);
    issue_op(K_DEQ, '0);
    issue_op(K_DEQ, '0);
    issue_op(K_DUMP, '0);

    // fill the stack past full, then overflow the queue with a transfer
    src_gaps  = ($urandom_range(0, 3) != 0);
    sink_gaps = ($urandom_range(0, 3) != 0);
    repeat (STACK_DEPTH + 2) issue_op(K_PUSH, $urandom);
    repeat ($urandom_range(4, 20)) issue_op(K_ENQ, $urandom);
    issue_op(K_XFER, $urandom);
    repeat (2) issue_op(K_ENQ, $urandom);
    sink_gaps = 1'b1;
    issue_op(K_DUMP, $urandom);
    repeat ($urandom_range(5, 15)) issue_op(K_DEQ, $urandom);
    issue_op(K_XFER, $urandom);
    issue_op(K_DUMP, $urandom);
    repeat ($urandom_range(3, 8)) issue_op(K_POP, $urandom);

    // mixed traffic, the tail without any hold-off
    for (int i = 0; i < 50; i++) begin
      if (i % 10 == 0) begin
        src_gaps  = ($urandom_range(0, 3) != 0);
        sink_gaps = ($urandom_range(0, 3) != 0);
      end
      if (i >= 35) begin
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 25)
        k = K_ENQ;
      else if (r < 50)
        k = K_PUSH;
      else if (r < 62)
        k = K_POP;
      else if (r < 74)
        k = K_DEQ;
      else if (r < 84)
        k = K_XFER;
      else if (r < 94)
        k = K_DUMP;
      else
        k = r[0] ? KIND_SPARE7 : KIND_SPARE6;
      issue_op(k, $urandom);
    end
    in_valid <= 1'b0;

    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_fail == 0 && n_pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/stq_pkg.sv
hw/rtl/stq_stores.sv
hw/rtl/stack_to_queue_transfer_top.sv
tb/stq_result_checker.sv
tb/tb_top.sv
